/* design/page_allocator_with_refcount_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the page allocator
// Clocked property wrappers shared by the files that carry checks.
// ----------------------------------------------------------------------------
`ifndef PAGE_ALLOCATOR_WITH_REFCOUNT_TOP_MACROS_SVH
`define PAGE_ALLOCATOR_WITH_REFCOUNT_TOP_MACROS_SVH

// checked at every edge, reset or not
`define PGALLOC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// checked only out of reset
`define PGALLOC_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

/* design/pgalloc_pkg.sv */
// ----------------------------------------------------------------------------
// pgalloc_pkg
// Sizes, operation codes and status codes of the page allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgalloc_pkg;

    // geometry
    localparam int NUM_PAGES = 4096;
    localparam int PAGE_AW   = $clog2(NUM_PAGES);
    localparam int DEPTH_W   = PAGE_AW + 1;
    localparam int PAGE_W    = 12;
    localparam int COUNT_W   = 8;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // operation codes
    localparam logic [MODE_W-1:0] MD_ALLOC = 3'd0;
    localparam logic [MODE_W-1:0] MD_FREE  = 3'd1;
    localparam logic [MODE_W-1:0] MD_ADD   = 3'd2;
    localparam logic [MODE_W-1:0] MD_SUB   = 3'd3;
    localparam logic [MODE_W-1:0] MD_QUERY = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FLOW  = 2'd3;

endpackage

/* design/pgalloc_ram.sv */
// ----------------------------------------------------------------------------
// pgalloc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgalloc_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/page_allocator_with_refcount_top.sv */
// ----------------------------------------------------------------------------
// page_allocator_with_refcount_top
// Page frame allocator: LIFO stack of free pages and a reference count per
// page, both held in synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+-------------------------------
//  in      | to block  | i_in_valid / o_in_stall  | i_mode, i_page_index
//  out     | from blk  | o_out_valid / i_out_stall| o_page_index_res, o_ref_count,
//          |           |                          | o_status
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_data (first usable page)
//
//  Each operation reads the count RAM and the stack RAM on the accept edge,
//  then modifies and writes back in S_EXEC.
//  After reset the count RAM is swept to 1, one entry a cycle, with o_in_stall
//  high until every entry is written. Configuration writes are taken throughout.
//  A word stalled at the output holds the write-back cycle until it is taken;
//  o_in_stall stays high meanwhile, so no new word is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_allocator_with_refcount_top_macros.svh"

module page_allocator_with_refcount_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // operation input
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pgalloc_pkg::MODE_W-1:0]     i_mode,
    input  logic [pgalloc_pkg::PAGE_W-1:0]     i_page_index,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pgalloc_pkg::PAGE_W-1:0]     o_page_index_res,
    output logic [pgalloc_pkg::COUNT_W-1:0]    o_ref_count,
    output logic [pgalloc_pkg::STATUS_W-1:0]   o_status,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pgalloc_pkg::PAGE_W-1:0]     i_cfg_data
);

    localparam int AW = pgalloc_pkg::PAGE_AW;
    localparam int DW = pgalloc_pkg::DEPTH_W;
    localparam int CW = pgalloc_pkg::COUNT_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} t_state;

    t_state                            r_state;
    logic [AW-1:0]                     r_clr_addr;
    logic [DW-1:0]                     r_depth;
    logic [pgalloc_pkg::PAGE_W-1:0]    r_first;
    logic [pgalloc_pkg::MODE_W-1:0]    r_mode;
    logic [pgalloc_pkg::PAGE_W-1:0]    r_page;
    logic                              r_out_valid;
    logic [pgalloc_pkg::PAGE_W-1:0]    r_res_page;
    logic [CW-1:0]                     r_res_cnt;
    logic [pgalloc_pkg::STATUS_W-1:0]  r_res_st;

    logic                              w_accept;
    logic                              w_commit;
    logic [CW-1:0]                     w_cnt_rd;
    logic [AW-1:0]                     w_top;

    // results of the write-back cycle
    logic [DW-1:0]                     n_depth;
    logic                              n_cnt_we;
    logic [AW-1:0]                     n_cnt_addr;
    logic [CW-1:0]                     n_cnt_data;
    logic                              n_push;
    logic [pgalloc_pkg::PAGE_W-1:0]    n_res_page;
    logic [CW-1:0]                     n_res_cnt;
    logic [pgalloc_pkg::STATUS_W-1:0]  n_res_st;
    logic                              w_out_range;

    // RAM port wiring
    logic                              w_cram_we;
    logic [AW-1:0]                     w_cram_waddr;
    logic [CW-1:0]                     w_cram_wdata;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_commit    = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_out_valid      = r_out_valid;
    assign o_page_index_res = r_res_page;
    assign o_ref_count      = r_res_cnt;
    assign o_status         = r_res_st;

    // reference count RAM
    assign w_cram_we    = (r_state == S_CLEAR) || (w_commit && n_cnt_we);
    assign w_cram_waddr = (r_state == S_CLEAR) ? r_clr_addr : n_cnt_addr;
    assign w_cram_wdata = (r_state == S_CLEAR) ? CW'(1) : n_cnt_data;

    pgalloc_ram #(
        .DEPTH (pgalloc_pkg::NUM_PAGES),
        .WIDTH (CW)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_cram_we),
        .i_waddr (w_cram_waddr),
        .i_wdata (w_cram_wdata),
        .i_re    (w_accept),
        .i_raddr (i_page_index[AW-1:0]),
        .o_rdata (w_cnt_rd)
    );

    // free page stack RAM, top read on accept
    pgalloc_ram #(
        .DEPTH (pgalloc_pkg::NUM_PAGES),
        .WIDTH (AW)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_commit && n_push),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (r_page[AW-1:0]),
        .i_re    (w_accept),
        .i_raddr (AW'(r_depth - DW'(1))),
        .o_rdata (w_top)
    );

    assign w_out_range = ({{(DW > pgalloc_pkg::PAGE_W ? DW - pgalloc_pkg::PAGE_W : 0){1'b0}},
                           r_page} >= (pgalloc_pkg::PAGE_W + 1)'(pgalloc_pkg::NUM_PAGES));

    // modify step
    always_comb begin
        n_depth    = r_depth;
        n_cnt_we   = 1'b0;
        n_cnt_addr = r_page[AW-1:0];
        n_cnt_data = w_cnt_rd;
        n_push     = 1'b0;
        n_res_page = r_page;
        n_res_cnt  = w_cnt_rd;
        n_res_st   = pgalloc_pkg::ST_OK;
        if (r_mode == pgalloc_pkg::MD_ALLOC) begin
            if (r_depth == '0) begin
                n_res_page = '0;
                n_res_cnt  = '0;
                n_res_st   = pgalloc_pkg::ST_EMPTY;
            end else begin
                n_depth    = r_depth - DW'(1);
                n_cnt_we   = 1'b1;
                n_cnt_addr = w_top;
                n_cnt_data = CW'(1);
                n_res_page = pgalloc_pkg::PAGE_W'(w_top);
                n_res_cnt  = CW'(1);
            end
        end else if (w_out_range) begin
            n_res_cnt = '0;
            n_res_st  = pgalloc_pkg::ST_RANGE;
        end else begin
            unique case (r_mode)
                pgalloc_pkg::MD_FREE: begin
                    if (r_page < r_first) begin
                        n_res_st = pgalloc_pkg::ST_RANGE;
                    end else if (w_cnt_rd == '0) begin
                        n_res_st = pgalloc_pkg::ST_FLOW;
                    end else if (w_cnt_rd > CW'(1)) begin
                        n_cnt_we   = 1'b1;
                        n_cnt_data = w_cnt_rd - CW'(1);
                        n_res_cnt  = w_cnt_rd - CW'(1);
                    end else if (r_depth >= DW'(pgalloc_pkg::NUM_PAGES)) begin
                        n_res_st = pgalloc_pkg::ST_FLOW;
                    end else begin
                        // last reference gone: page goes on the stack
                        n_cnt_we   = 1'b1;
                        n_cnt_data = '0;
                        n_res_cnt  = '0;
                        n_push     = 1'b1;
                        n_depth    = r_depth + DW'(1);
                    end
                end
                pgalloc_pkg::MD_ADD: begin
                    if (w_cnt_rd == pgalloc_pkg::COUNT_MAX) begin
                        n_res_st = pgalloc_pkg::ST_FLOW;
                    end else begin
                        n_cnt_we   = 1'b1;
                        n_cnt_data = w_cnt_rd + CW'(1);
                        n_res_cnt  = w_cnt_rd + CW'(1);
                    end
                end
                pgalloc_pkg::MD_SUB: begin
                    if (w_cnt_rd == '0) begin
                        n_res_st = pgalloc_pkg::ST_FLOW;
                    end else begin
                        n_cnt_we   = 1'b1;
                        n_cnt_data = w_cnt_rd - CW'(1);
                        n_res_cnt  = w_cnt_rd - CW'(1);
                    end
                end
                default: begin
                    // query, and the unused codes behave as query
                end
            endcase
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_first <= i_cfg_data;
        end
    end

    // sequencer, stack depth and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new word replaces the one taken at the same edge
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(pgalloc_pkg::NUM_PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                        r_depth <= n_depth;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // operation and result words
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_page <= i_page_index;
        end
        if (w_commit) begin
            r_res_page <= n_res_page;
            r_res_cnt  <= n_res_cnt;
            r_res_st   <= n_res_st;
        end
    end

    // checks
    `PGALLOC_ASSERT_ALWAYS(a_cfg_open, o_cfg_ready, "config channel not ready")
    `PGALLOC_ASSERT_RUN(a_accept_to_exec, w_accept |=> (r_state == S_EXEC), "no write-back")
    `PGALLOC_ASSERT_RUN(a_depth_bound, (r_depth <= DW'(pgalloc_pkg::NUM_PAGES)), "depth overrun")
    `PGALLOC_ASSERT_RUN(a_empty_word, (o_out_valid && (o_status == pgalloc_pkg::ST_EMPTY)) |-> ((o_ref_count == '0) && (o_page_index_res == '0)), "empty alloc result not zero")
    `PGALLOC_ASSERT_RUN(a_push_grows, (w_commit && n_push) |=> (r_depth == $past(r_depth) + DW'(1)), "push did not grow the stack")

endmodule
